/* rtl/tla_pkg.sv */
`timescale 1ns / 1ps

package tla_pkg;

	// Grid geometry
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLUMNS = 64;
	localparam int ROW_W       = 6;
	localparam int COL_W       = 6;
	localparam int CNT_W       = 7;
	localparam int ROW_CAP     = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int COL_CAP     = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

	// Configuration register indexes
	localparam logic CFG_ROWS    = 1'b0;
	localparam logic CFG_COLUMNS = 1'b1;

	// Item operation codes
	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_PLACE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_STEP  = 2'd3
	} action_t;

	// Ant headings
	typedef enum logic [1:0] {
		HEAD_UP    = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_DOWN  = 2'd2,
		HEAD_LEFT  = 2'd3
	} heading_t;

	// Controller to datapath
	typedef struct packed {
		logic             clear;
		logic [ROW_W-1:0] clr_addr;
		logic             accept;
		logic             exec;
	} tla_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} tla_stat_t;

endpackage

/* rtl/tla_ram.sv */
`timescale 1ns / 1ps

module tla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/tla_ctrl.sv */
`timescale 1ns / 1ps

module tla_ctrl import tla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tla_stat_t stat,
	output tla_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] clr_cnt_q;
	logic             ready_q;

	// Sequencer: clear pass, then accept / execute per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			ready_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ROW_W'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					// wait here while the result register is still occupied
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready     = ready_q;
	assign cmd.clear    = (state_q == ST_CLEAR);
	assign cmd.clr_addr = clr_cnt_q;
	assign cmd.accept   = in_valid && ready_q;
	assign cmd.exec     = (state_q == ST_EXEC) && stat.out_free;

endmodule

/* rtl/tla_dp.sv */
`timescale 1ns / 1ps

module tla_dp import tla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tla_cmd_t         cmd,
	output tla_stat_t        stat,
	// configuration
	input  logic             cfg_we,
	input  logic             cfg_sel,
	input  logic [CNT_W-1:0] cfg_wdata,
	// item fields
	input  action_t          in_action,
	input  logic [ROW_W-1:0] in_row,
	input  logic [COL_W-1:0] in_col,
	input  logic             in_value,
	input  logic [1:0]       in_heading,
	// result
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_read_value,
	output logic [ROW_W-1:0] out_ant_row,
	output logic [COL_W-1:0] out_ant_col,
	output logic [1:0]       out_ant_heading,
	output logic             out_range_error
);

	logic [CNT_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [CNT_W-1:0] rows_eff, cols_eff;
	logic [ROW_W-1:0] ant_row_q;
	logic [COL_W-1:0] ant_col_q;
	logic [1:0]       ant_head_q;

	action_t          act_q;
	logic [ROW_W-1:0] trow_q;
	logic [COL_W-1:0] tcol_q;
	logic             val_q;
	logic [1:0]       head_q;

	logic                   out_valid_q;
	logic                   rd_q;
	logic [ROW_W-1:0]       orow_q;
	logic [COL_W-1:0]       ocol_q;
	logic [1:0]             ohead_q;
	logic                   err_q;

	logic [MAX_COLUMNS-1:0] row_rdata, row_wdata, row_mod;
	logic                   ram_we;
	logic [ROW_W-1:0]       ram_waddr, ram_raddr, cur_row;
	logic [COL_W-1:0]       cur_col;
	logic                   cell_bit, new_bit, is_step, range_err;
	logic [1:0]             step_head;
	logic [ROW_W-1:0]       nxt_row;
	logic [COL_W-1:0]       nxt_col;
	logic [1:0]             nxt_head;
	logic                   res_rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CNT_W'(64);
			cols_cfg_q <= CNT_W'(64);
		end else if (cfg_we) begin
			if (cfg_sel == CFG_ROWS) begin
				rows_cfg_q <= cfg_wdata;
			end else begin
				cols_cfg_q <= cfg_wdata;
			end
		end
	end

	// Saturate counts to 1 .. cap
	always_comb begin
		if (rows_cfg_q == '0) rows_eff = CNT_W'(1);
		else if (rows_cfg_q > CNT_W'(ROW_CAP)) rows_eff = CNT_W'(ROW_CAP);
		else rows_eff = rows_cfg_q;
		if (cols_cfg_q == '0) cols_eff = CNT_W'(1);
		else if (cols_cfg_q > CNT_W'(COL_CAP)) cols_eff = CNT_W'(COL_CAP);
		else cols_eff = cols_cfg_q;
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q  <= in_action;
			trow_q <= in_row;
			tcol_q <= in_col;
			val_q  <= in_value;
			head_q <= in_heading;
		end
	end

	// Execute: cell select, range check, step turn and move, place, read and cell update
	always_comb begin
		is_step   = (act_q == ACT_STEP);
		cur_row   = is_step ? ant_row_q : trow_q;
		cur_col   = is_step ? ant_col_q : tcol_q;
		cell_bit  = row_rdata[cur_col];
		range_err = !is_step && (({1'b0, trow_q} >= rows_eff) || ({1'b0, tcol_q} >= cols_eff));
		step_head = cell_bit ? (ant_head_q - 2'd1) : (ant_head_q + 2'd1);

		nxt_row  = ant_row_q;
		nxt_col  = ant_col_q;
		nxt_head = ant_head_q;
		res_rd   = 1'b0;
		new_bit  = val_q;

		if (is_step) begin
			res_rd   = cell_bit;
			new_bit  = ~cell_bit;
			nxt_head = step_head;
			case (heading_t'(step_head))
				HEAD_UP:
					nxt_row = (ant_row_q == '0) ? ROW_W'(rows_eff - 1'b1) : ant_row_q - 1'b1;
				HEAD_RIGHT:
					nxt_col = (({1'b0, ant_col_q} + 1'b1) >= cols_eff) ? '0 : ant_col_q + 1'b1;
				HEAD_DOWN:
					nxt_row = (({1'b0, ant_row_q} + 1'b1) >= rows_eff) ? '0 : ant_row_q + 1'b1;
				default:
					nxt_col = (ant_col_q == '0) ? COL_W'(cols_eff - 1'b1) : ant_col_q - 1'b1;
			endcase
		end else if (!range_err) begin
			case (act_q)
				ACT_PLACE: begin
					nxt_row  = trow_q;
					nxt_col  = tcol_q;
					nxt_head = head_q;
				end
				ACT_READ: res_rd = cell_bit;
				default: ;
			endcase
		end

		row_mod          = row_rdata;
		row_mod[cur_col] = new_bit;
	end

	// Grid row memory port control
	assign ram_raddr = (in_action == ACT_STEP) ? ant_row_q : in_row;
	assign ram_we    = cmd.clear ||
	                   (cmd.exec && (is_step || (act_q == ACT_WRITE && !range_err)));
	assign ram_waddr = cmd.clear ? cmd.clr_addr : cur_row;
	assign row_wdata = cmd.clear ? '0 : row_mod;

	tla_ram #(
		.WIDTH(MAX_COLUMNS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(row_wdata),
		.re   (cmd.accept),
		.raddr(ram_raddr),
		.rdata(row_rdata)
	);

	// Ant state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_row_q  <= '0;
			ant_col_q  <= '0;
			ant_head_q <= HEAD_UP;
		end else if (cmd.exec) begin
			ant_row_q  <= nxt_row;
			ant_col_q  <= nxt_col;
			ant_head_q <= nxt_head;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q    <= res_rd;
			orow_q  <= nxt_row;
			ocol_q  <= nxt_col;
			ohead_q <= nxt_head;
			err_q   <= range_err;
		end
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_read_value  = rd_q;
	assign out_ant_row     = orow_q;
	assign out_ant_col     = ocol_q;
	assign out_ant_heading = ohead_q;
	assign out_range_error = err_q;

endmodule

/* rtl/toroidal_langton_ant_step.sv */
`timescale 1ns / 1ps

// Langton's ant on a toroidal grid of one-bit cells.
// Input stream: s_axis_tuser carries the action (write cell, place ant, read cell,
// step); s_axis_tdata carries the target row/column, the cell value and the heading.
// Output stream: one result per input transaction with the cell read (or the color
// before the flip on a step), the ant position and heading after the item, and a
// range error flag.
// Config channel: cfg_index 0 sets rows in use, 1 sets columns in use; always ready,
// write only while the block is idle.
// Timing: an item is first read as a grid row from memory, then written back
// modified. One item is worked on at a time, so the next input transaction is
// taken only once the last item has been written back, and the result is
// registered at that write-back.
// Reset: the grid is cleared by a pass over every row, one row per cycle, during
// which s_axis_tready stays low. The ant returns to row 0, column 0, heading up.
// Stall: the result waits in the output register; the next item is still taken and
// read, and holds before its write-back until the output register frees up.

module toroidal_langton_ant_step import tla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [5:0] target_row, [11:6] target_column,
	                                   // [12] cell_value, [14:13] heading, [15] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] action
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] read_value, [6:1] ant_row, [12:7] ant_column,
	                                   // [14:13] ant_heading, [15] range_error
);

	tla_cmd_t  cmd;
	tla_stat_t stat;

	assign cfg_ready = 1'b1;

	tla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tla_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_sel        (cfg_index),
		.cfg_wdata      (cfg_data),
		.in_action      (action_t'(s_axis_tuser)),
		.in_row         (s_axis_tdata[5:0]),
		.in_col         (s_axis_tdata[11:6]),
		.in_value       (s_axis_tdata[12]),
		.in_heading     (s_axis_tdata[14:13]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_read_value (m_axis_tdata[0]),
		.out_ant_row    (m_axis_tdata[6:1]),
		.out_ant_col    (m_axis_tdata[12:7]),
		.out_ant_heading(m_axis_tdata[14:13]),
		.out_range_error(m_axis_tdata[15])
	);

endmodule

/* rtl/tla_checker.sv */
`timescale 1ns / 1ps

module tla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// Held result stays put while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// One item in flight: ready drops right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// With the output empty, the result shows right after the write-back, which does not stall
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid ##1 m_axis_tvalid)
		else $error("result latency wrong");

endmodule

bind toroidal_langton_ant_step tla_checker u_tla_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import tla_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 136;
	localparam int SETTLE_CYCLES = 4;

	// One result transaction, laid out as m_axis_tdata (first member is the top bit)
	typedef struct packed {
		logic             err;
		heading_t         hd;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             rd;
	} ant_report_t;

	// One row of the directed plan: either a geometry change or an item
	typedef struct {
		bit          is_cfg;
		int          cfg_rows;
		int          cfg_cols;
		action_t     act;
		int          row;
		int          col;
		int          val;
		heading_t    head;
		bit          has_lit;
		ant_report_t lit;
	} plan_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = CFG_ROWS;
	logic [6:0]  cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	// Shadow of the block: grid, ant and raw register values
	bit                 grid_model [0:MAX_ROWS*MAX_COLUMNS-1];
	logic [ROW_W-1:0]   ant_r;
	logic [COL_W-1:0]   ant_c;
	heading_t           ant_h;
	logic [CNT_W-1:0]   rows_cfg;
	logic [CNT_W-1:0]   cols_cfg;

	ant_report_t pending_reports [$];
	plan_row_t   plan [$];

	int mismatches;
	int items_sent;
	int steps_sent;
	int range_flags;
	int results_seen;
	int geometries;
	int burst_left;
	bit gaps_on;
	int idle_cycles;
	int stall_mode;
	int stall_tick;
	int cycle_count;

	toroidal_langton_ant_step u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Register value to the count actually used: 0 acts as 1, too large saturates
	function automatic int span(logic [CNT_W-1:0] v, int cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return int'(v);
	endfunction

	// Advance the shadow by one accepted item and return the result it causes
	function automatic ant_report_t ant_outcome(action_t act, logic [ROW_W-1:0] trow,
			logic [COL_W-1:0] tcol, logic val, heading_t head);
		ant_report_t rep;
		int          rows;
		int          cols;
		logic        colour;
		rows = span(rows_cfg, ROW_CAP);
		cols = span(cols_cfg, COL_CAP);
		rep  = '0;
		if (act == ACT_STEP) begin
			// turn on the color under the ant, flip it, then move with wraparound
			colour = grid_model[{ant_r, ant_c}];
			rep.rd = colour;
			ant_h  = colour ? heading_t'(ant_h - 2'd1) : heading_t'(ant_h + 2'd1);
			grid_model[{ant_r, ant_c}] = ~colour;
			case (ant_h)
				HEAD_UP: begin
					ant_r = (ant_r == 0) ? ROW_W'(rows - 1) : ant_r - 1'b1;
				end
				HEAD_RIGHT: begin
					ant_c = (int'(ant_c) + 1 >= cols) ? '0 : ant_c + 1'b1;
				end
				HEAD_DOWN: begin
					ant_r = (int'(ant_r) + 1 >= rows) ? '0 : ant_r + 1'b1;
				end
				default: begin
					ant_c = (ant_c == 0) ? COL_W'(cols - 1) : ant_c - 1'b1;
				end
			endcase
		end else if (trow >= rows || tcol >= cols) begin
			rep.err = 1'b1;
		end else begin
			case (act)
				ACT_WRITE: grid_model[{trow, tcol}] = val;
				ACT_PLACE: begin
					ant_r = trow;
					ant_c = tcol;
					ant_h = head;
				end
				default: rep.rd = grid_model[{trow, tcol}];
			endcase
		end
		rep.row = ant_r;
		rep.col = ant_c;
		rep.hd  = ant_h;
		return rep;
	endfunction

	function automatic void plan_cfg(int r, int c);
		plan_row_t p;
		p          = '{default: 0, act: ACT_WRITE, head: HEAD_UP, lit: '0};
		p.is_cfg   = 1'b1;
		p.cfg_rows = r;
		p.cfg_cols = c;
		plan.push_back(p);
	endfunction

	function automatic void plan_item(action_t act, int row, int col, int val, heading_t head);
		plan_row_t p;
		p      = '{default: 0, act: ACT_WRITE, head: HEAD_UP, lit: '0};
		p.act  = act;
		p.row  = row;
		p.col  = col;
		p.val  = val;
		p.head = head;
		plan.push_back(p);
	endfunction

	// Attach a hand-written expectation to the last planned item
	function automatic void plan_lit(int rd, int ar, int ac, heading_t ah, int err);
		int last;
		last = plan.size() - 1;
		plan[last].has_lit = 1'b1;
		plan[last].lit.rd  = 1'(rd);
		plan[last].lit.row = ROW_W'(ar);
		plan[last].lit.col = COL_W'(ac);
		plan[last].lit.hd  = ah;
		plan[last].lit.err = 1'(err);
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Drop valid and wait until every expected result is back, then let the block settle
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both geometry registers while the block is idle
	task automatic set_geometry(int r, int c);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= CNT_W'(r);
		do @(posedge clk); while (!cfg_ready);
		rows_cfg = CNT_W'(r);
		cfg_index <= CFG_COLUMNS;
		cfg_data  <= CNT_W'(c);
		do @(posedge clk); while (!cfg_ready);
		cols_cfg = CNT_W'(c);
		cfg_valid <= 1'b0;
		geometries++;
	endtask

	// One input transaction, sent in bursts with random gaps between them when gaps_on is set
	task automatic send_item(action_t act, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
			logic val, heading_t head, bit has_lit, ant_report_t lit);
		ant_report_t predicted;
		int          gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {1'b0, head, val, col, row};
		do @(posedge clk); while (!s_axis_tready);
		predicted = ant_outcome(act, row, col, val, head);
		pending_reports.push_back(has_lit ? lit : predicted);
		items_sent++;
		if (act == ACT_STEP) steps_sent++;
		if (predicted.err) range_flags++;
	endtask

	// Receiver readiness: picks one of four stall modes anew whenever its tick counter runs out
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_tick == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_tick <= $urandom_range(40, 80);
		end else begin
			stall_tick <= stall_tick - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 9) != 0);
			default: m_axis_tready <= (cycle_count[2:0] < 3'd2);
		endcase
	end

	// Result checker: compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		ant_report_t got;
		ant_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got = ant_report_t'(m_axis_tdata);
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
			end else begin
				want = pending_reports.pop_front();
				if (got.rd !== want.rd)
					report_mismatch($sformatf("read_value %b, want %b", got.rd, want.rd));
				if (got.row !== want.row)
					report_mismatch($sformatf("ant_row %0d, want %0d", got.row, want.row));
				if (got.col !== want.col)
					report_mismatch($sformatf("ant_column %0d, want %0d", got.col, want.col));
				if (got.hd !== want.hd)
					report_mismatch($sformatf("ant_heading %0d, want %0d", got.hd, want.hd));
				if (got.err !== want.err)
					report_mismatch($sformatf("range_error %b, want %b", got.err, want.err));
			end
		end
	end

	// Watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int      r_raw;
		int      c_raw;
		int      rows;
		int      cols;
		int      sel;
		int      trow;
		int      tcol;
		action_t act;

		ant_r    = '0;
		ant_c    = '0;
		ant_h    = HEAD_UP;
		rows_cfg = CNT_W'(64);
		cols_cfg = CNT_W'(64);

		// Directed plan: extremes, every action, range errors, shrink and saturation
		plan_item(ACT_READ, 0, 0, 0, HEAD_UP);       plan_lit(0, 0, 0, HEAD_UP, 0);
		plan_item(ACT_WRITE, 63, 63, 1, HEAD_LEFT);  plan_lit(0, 0, 0, HEAD_UP, 0);
		plan_item(ACT_READ, 63, 63, 0, HEAD_RIGHT);  plan_lit(1, 0, 0, HEAD_UP, 0);
		plan_item(ACT_PLACE, 63, 0, 1, HEAD_LEFT);   plan_lit(0, 63, 0, HEAD_LEFT, 0);
		plan_item(ACT_STEP, 63, 63, 1, HEAD_DOWN);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		plan_item(ACT_PLACE, 0, 63, 0, HEAD_RIGHT);  plan_lit(0, 0, 63, HEAD_RIGHT, 0);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_LEFT);
		plan_item(ACT_WRITE, 0, 0, 1, HEAD_DOWN);
		plan_item(ACT_PLACE, 0, 0, 0, HEAD_UP);      plan_lit(0, 0, 0, HEAD_UP, 0);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		plan_item(ACT_STEP, 63, 63, 1, HEAD_RIGHT);
		plan_cfg(4, 5);
		plan_item(ACT_PLACE, 3, 4, 0, HEAD_DOWN);    plan_lit(0, 3, 4, HEAD_DOWN, 0);
		plan_item(ACT_READ, 4, 0, 0, HEAD_UP);       plan_lit(0, 3, 4, HEAD_DOWN, 1);
		plan_item(ACT_WRITE, 0, 5, 1, HEAD_UP);      plan_lit(0, 3, 4, HEAD_DOWN, 1);
		plan_item(ACT_PLACE, 63, 63, 1, HEAD_UP);    plan_lit(0, 3, 4, HEAD_DOWN, 1);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		plan_item(ACT_READ, 0, 5, 0, HEAD_UP);
		plan_cfg(64, 64);
		plan_item(ACT_PLACE, 40, 50, 0, HEAD_UP);    plan_lit(0, 40, 50, HEAD_UP, 0);
		// ant left outside the grid after it shrinks
		plan_cfg(8, 8);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		// zero counts act as one
		plan_cfg(0, 0);
		plan_item(ACT_PLACE, 0, 0, 0, HEAD_LEFT);    plan_lit(0, 0, 0, HEAD_LEFT, 0);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);
		plan_item(ACT_READ, 0, 1, 0, HEAD_UP);
		// oversized counts saturate to the full grid
		plan_cfg(127, 127);
		plan_item(ACT_PLACE, 63, 63, 0, HEAD_DOWN);  plan_lit(0, 63, 63, HEAD_DOWN, 0);
		plan_item(ACT_STEP, 0, 0, 0, HEAD_UP);

		repeat (2) @(posedge clk);
		arst_n  <= 1'b1;
		gaps_on = 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_geometry(plan[i].cfg_rows, plan[i].cfg_cols);
			end else begin
				send_item(plan[i].act, ROW_W'(plan[i].row), COL_W'(plan[i].col),
					1'(plan[i].val), plan[i].head, plan[i].has_lit, plan[i].lit);
			end
		end

		// Random phases: a geometry each, then mostly ant walks with scattered edits
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin r_raw = 64;  c_raw = 64;  end
				1: begin r_raw = 1;   c_raw = 1;   end
				2: begin r_raw = 0;   c_raw = 127; end
				3: begin r_raw = 127; c_raw = 0;   end
				4: begin r_raw = 1;   c_raw = 64;  end
				5: begin r_raw = 64;  c_raw = 1;   end
				default: begin
					r_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(2, 16);
					c_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(2, 16);
				end
			endcase
			set_geometry(r_raw, c_raw);
			gaps_on = (ph % 4 != 1);
			rows = span(CNT_W'(r_raw), ROW_CAP);
			cols = span(CNT_W'(c_raw), COL_CAP);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// sender holds off until the block has drained
				if (k == PHASE_ITEMS / 2 && ph % 3 == 0) wait_quiet();
				sel = $urandom_range(0, 19);
				if (sel < 12)      act = ACT_STEP;
				else if (sel < 15) act = ACT_WRITE;
				else if (sel < 18) act = ACT_READ;
				else               act = ACT_PLACE;
				trow = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, rows - 1);
				tcol = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, cols - 1);
				send_item(act, ROW_W'(trow), COL_W'(tcol), 1'($urandom_range(0, 1)),
					heading_t'($urandom_range(0, 3)), 1'b0, '0);
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		$display("Ran %0d items (%0d ant steps, %0d out-of-range targets) over %0d geometries.",
			items_sent, steps_sent, range_flags, geometries);
		$display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/tla_pkg.sv
rtl/tla_ram.sv
rtl/tla_ctrl.sv
rtl/tla_dp.sv
rtl/toroidal_langton_ant_step.sv
rtl/tla_checker.sv
verif/testbench.sv
